// File: hw/rtl/stt_pkg.sv
// Shared types, character codes and helper functions of the source text tokenizer.
package stt_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int LOC_BITS     = 16;

  // Token kinds
  localparam logic [3:0] KIND_WORD   = 4'd0;
  localparam logic [3:0] KIND_INT    = 4'd1;
  localparam logic [3:0] KIND_STRING = 4'd2;
  localparam logic [3:0] KIND_LPAREN = 4'd3;
  localparam logic [3:0] KIND_RPAREN = 4'd4;
  localparam logic [3:0] KIND_LCURL  = 4'd5;
  localparam logic [3:0] KIND_RCURL  = 4'd6;
  localparam logic [3:0] KIND_SEMI   = 4'd7;
  localparam logic [3:0] KIND_COMMA  = 4'd8;
  localparam logic [3:0] KIND_END    = 4'd9;
  localparam logic [3:0] KIND_ERROR  = 4'd10;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LCURL  = 8'h7B;
  localparam logic [7:0] CH_RCURL  = 8'h7D;

  typedef struct packed {
    logic [3:0]          token_kind;
    logic                has_char;
    logic [7:0]          char_out;
    logic [LOC_BITS-1:0] start_line;
    logic [LOC_BITS-1:0] start_column;
    logic                token_first;
    logic                token_last;
  } tok_t;

  // One queue entry: the one or two results caused by one source byte.
  typedef struct packed {
    logic two;
    tok_t res0;
    tok_t res1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } beat_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_TAB || b == CH_VT || b == CH_NL || b == CH_SPACE;
  endfunction

  function automatic logic punct_hit(input logic [7:0] b);
    return b == CH_LPAREN || b == CH_RPAREN || b == CH_LCURL ||
           b == CH_RCURL || b == CH_SEMI || b == CH_COMMA;
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] b);
    logic [3:0] k;
    unique case (b)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LCURL:  k = KIND_LCURL;
      CH_RCURL:  k = KIND_RCURL;
      CH_SEMI:   k = KIND_SEMI;
      CH_COMMA:  k = KIND_COMMA;
      default:   k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // Saturate a location count to the 16-bit output field.
  function automatic logic [LOC_BITS-1:0] clamp_loc(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? '1 : v[LOC_BITS-1:0];
  endfunction

  function automatic tok_t make_tok(input logic [3:0] kind, input logic has,
                                    input logic [7:0] ch,
                                    input logic [LOC_BITS-1:0] ln,
                                    input logic [LOC_BITS-1:0] col,
                                    input logic first, input logic last);
    tok_t t;
    t.token_kind   = kind;
    t.has_char     = has;
    t.char_out     = has ? ch : CH_NUL;
    t.start_line   = ln;
    t.start_column = col;
    t.token_first  = first;
    t.token_last   = last;
    return t;
  endfunction

endpackage

// File: hw/rtl/stt_in_if.sv
// Source byte channel: valid/ready handshake with one byte of payload.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink   (input valid, input byte_value, output ready);
endinterface

// File: hw/rtl/stt_out_if.sv
// Token result channel: valid/ready handshake with the token item fields.
interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic        has_char;
  logic [7:0]  char_out;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic        token_first;
  logic        token_last;

  modport source (output valid, output token_kind, output has_char, output char_out,
                  output start_line, output start_column, output token_first,
                  output token_last, input ready);
  modport sink   (input valid, input token_kind, input has_char, input char_out,
                  input start_line, input start_column, input token_first,
                  input token_last, output ready);
endinterface

// File: hw/rtl/stt_front.sv
// Scanner front end: tracks location and scan mode, builds the results of each byte.
module stt_front #(
  parameter int POSITION_BITS = stt_pkg::POS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  output logic               in_ready,
  input  logic               q_full,
  output stt_pkg::beat_t     push
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  typedef enum logic [5:0] {
    M_IDLE     = 6'b000001,
    M_WORD     = 6'b000010,
    M_INT      = 6'b000100,
    M_STR_OPEN = 6'b001000,
    M_STR_BODY = 6'b010000,
    M_HALT     = 6'b100000
  } mode_t;

  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt;
  logic [POSITION_BITS-1:0] col_r, col_nxt;
  logic [POSITION_BITS-1:0] tok_line_r, tok_line_nxt;
  logic [POSITION_BITS-1:0] tok_col_r, tok_col_nxt;

  logic [POSITION_BITS-1:0] line_a, col_a;
  logic [15:0]              la16, ca16, tl16, tc16;
  logic                     acc;
  logic                     use_idle, closed, more, is_word, str_open;
  logic [3:0]               run_kind;
  stt_pkg::tok_t            r0, r1, ir;
  logic                     ir_v, ir_tokload, ir_locreset;
  mode_t                    ir_mode;
  logic [1:0]               nres;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // Location after this byte
  always_comb begin
    col_a  = (col_r < POS_MAX) ? col_r + POS_ONE : col_r;
    line_a = line_r;
    if (in_byte == stt_pkg::CH_NL) begin
      line_a = (line_r < POS_MAX) ? line_r + POS_ONE : line_r;
      col_a  = POS_ONE;
    end
  end

  assign la16 = stt_pkg::clamp_loc(32'(line_a));
  assign ca16 = stt_pkg::clamp_loc(32'(col_a));
  assign tl16 = stt_pkg::clamp_loc(32'(tok_line_r));
  assign tc16 = stt_pkg::clamp_loc(32'(tok_col_r));

  // Idle handling of the byte, used from idle and after a word or int closes
  always_comb begin
    ir          = '0;
    ir_v        = 1'b0;
    ir_tokload  = 1'b0;
    ir_locreset = 1'b0;
    ir_mode     = M_IDLE;
    priority if (stt_pkg::is_space(in_byte)) begin
      ir_v = 1'b0;
    end else if (in_byte == stt_pkg::CH_NUL) begin
      ir_v        = 1'b1;
      ir_locreset = 1'b1;
      ir = stt_pkg::make_tok(stt_pkg::KIND_END, 1'b0, in_byte, '0, '0, 1'b1, 1'b1);
    end else if (stt_pkg::is_alpha(in_byte) || stt_pkg::is_digit(in_byte) ||
                 in_byte == stt_pkg::CH_UNDER) begin
      ir_v       = 1'b1;
      ir_tokload = 1'b1;
      ir_mode    = stt_pkg::is_digit(in_byte) ? M_INT : M_WORD;
      ir = stt_pkg::make_tok(stt_pkg::is_digit(in_byte) ? stt_pkg::KIND_INT
                                                        : stt_pkg::KIND_WORD,
                             1'b1, in_byte, la16, ca16, 1'b1, 1'b0);
    end else if (in_byte == stt_pkg::CH_QUOTE) begin
      ir_mode = M_STR_OPEN;
    end else if (stt_pkg::punct_hit(in_byte)) begin
      ir_v = 1'b1;
      ir = stt_pkg::make_tok(stt_pkg::punct_kind(in_byte), 1'b1, in_byte, la16, ca16,
                             1'b1, 1'b1);
    end else begin
      ir_v    = 1'b1;
      ir_mode = M_HALT;
      ir = stt_pkg::make_tok(stt_pkg::KIND_ERROR, 1'b0, in_byte, la16, ca16, 1'b1, 1'b1);
    end
  end

  assign is_word  = (mode_r == M_WORD);
  assign str_open = (mode_r == M_STR_OPEN);
  assign run_kind = is_word ? stt_pkg::KIND_WORD : stt_pkg::KIND_INT;
  assign more     = stt_pkg::is_alpha(in_byte) || stt_pkg::is_digit(in_byte) ||
                    (is_word && in_byte == stt_pkg::CH_UNDER);

  always_comb begin
    mode_nxt     = mode_r;
    line_nxt     = line_r;
    col_nxt      = col_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    r0           = '0;
    r1           = '0;
    nres         = 2'd0;
    use_idle     = 1'b0;
    closed       = 1'b0;
    if (acc && mode_r != M_HALT) begin
      line_nxt = line_a;
      col_nxt  = col_a;
      unique case (mode_r)
        M_WORD, M_INT: begin
          nres = 2'd1;
          if (more) begin
            r0 = stt_pkg::make_tok(run_kind, 1'b1, in_byte, tl16, tc16, 1'b0, 1'b0);
          end else begin
            r0       = stt_pkg::make_tok(run_kind, 1'b0, in_byte, tl16, tc16, 1'b0, 1'b1);
            closed   = 1'b1;
            use_idle = 1'b1;
          end
        end
        M_STR_OPEN, M_STR_BODY: begin
          nres = 2'd1;
          if (in_byte == stt_pkg::CH_NUL) begin
            r0 = stt_pkg::make_tok(stt_pkg::KIND_ERROR, 1'b0, in_byte, la16, ca16,
                                   1'b1, 1'b1);
            mode_nxt = M_HALT;
          end else begin
            if (str_open) begin
              tok_line_nxt = line_a;
              tok_col_nxt  = col_a;
            end
            if (in_byte == stt_pkg::CH_QUOTE) begin
              r0 = stt_pkg::make_tok(stt_pkg::KIND_STRING, 1'b0, in_byte,
                                     str_open ? la16 : tl16, str_open ? ca16 : tc16,
                                     str_open, 1'b1);
              mode_nxt = M_IDLE;
            end else begin
              r0 = stt_pkg::make_tok(stt_pkg::KIND_STRING, 1'b1, in_byte,
                                     str_open ? la16 : tl16, str_open ? ca16 : tc16,
                                     str_open, 1'b0);
              mode_nxt = M_STR_BODY;
            end
          end
        end
        M_IDLE:  use_idle = 1'b1;
        default: mode_nxt = mode_r;
      endcase
      if (use_idle) begin
        mode_nxt = ir_mode;
        if (ir_v) begin
          if (closed) r1 = ir;
          else        r0 = ir;
          nres = nres + 2'd1;
        end
        if (ir_tokload) begin
          tok_line_nxt = line_a;
          tok_col_nxt  = col_a;
        end
        if (ir_locreset) begin
          line_nxt = POS_ONE;
          col_nxt  = '0;
        end
      end
    end
  end

  assign push.valid      = (nres != 2'd0);
  assign push.entry.two  = (nres == 2'd2);
  assign push.entry.res0 = r0;
  assign push.entry.res1 = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      line_r     <= POS_ONE;
      col_r      <= '0;
      tok_line_r <= '0;
      tok_col_r  <= '0;
    end else begin
      mode_r     <= mode_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
    end
  end

endmodule

// File: hw/rtl/stt_queue.sv
// Short result queue between scanner front end and output back end.
module stt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  stt_pkg::beat_t push,
  input  logic           pop,
  output logic           full,
  output stt_pkg::beat_t head
);

  localparam int DEPTH  = stt_pkg::QUEUE_DEPTH;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  stt_pkg::entry_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head.valid = (cnt_r != '0);
  assign head.entry = mem[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push.entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/stt_back.sv
// Output back end: splits queue entries into single results behind an output register.
module stt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  stt_pkg::beat_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output stt_pkg::tok_t  out_tok
);

  logic          out_valid_r, out_valid_nxt;
  stt_pkg::tok_t out_tok_r, out_tok_nxt;
  logic          sel_r, sel_nxt;
  logic          load, entry_done;

  assign load       = head.valid && (!out_valid_r || out_ready);
  assign entry_done = !head.entry.two || sel_r;
  assign pop        = load && entry_done;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_tok_nxt   = out_tok_r;
    sel_nxt       = sel_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_tok_nxt   = sel_r ? head.entry.res1 : head.entry.res0;
      sel_nxt       = !entry_done;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_tok_r <= out_tok_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;

endmodule

// File: hw/rtl/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
//
//  channel  | dir | payload                                   | beat taken when
//  ---------+-----+-------------------------------------------+----------------------
//  in_if    | in  | byte_value[7:0]                           | valid && ready
//  out_if   | out | token_kind, has_char, char_out, location, | valid && ready
//           |     | token_first, token_last                   |
//
//  Cycles: one source byte is taken every cycle while the result queue has room.
//  A byte yields zero, one or two results, the 4-entry queue absorbing the extra one;
//  the back end sends one result per cycle while out_if.ready is high.
//  An input beat reaches the output through the queue write and then the output register.
//  Reset: synchronous, active low; clears scan mode, location, queue and output valid.
//  Stalls: out_if.ready low fills the queue; in_if.ready drops only when it is full.
//  After an error result the scanner halts: bytes are still taken and dropped.
module source_text_tokenizer #(
  parameter int POSITION_BITS = stt_pkg::POS_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  stt_in_if.sink   in_if,
  stt_out_if.source out_if
);

  stt_pkg::beat_t push;
  stt_pkg::beat_t head;
  stt_pkg::tok_t  out_tok;
  logic           q_full;
  logic           pop;

  // Front end: classify each byte, update location, build its results
  stt_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_byte  (in_if.byte_value),
    .in_ready (in_if.ready),
    .q_full   (q_full),
    .push     (push)
  );

  // Queue: hold results of up to four bytes so either side may stall
  stt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // Back end: drain entries one result per beat
  stt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_tok   (out_tok)
  );

  assign out_if.token_kind   = out_tok.token_kind;
  assign out_if.has_char     = out_tok.has_char;
  assign out_if.char_out     = out_tok.char_out;
  assign out_if.start_line   = out_tok.start_line;
  assign out_if.start_column = out_tok.start_column;
  assign out_if.token_first  = out_tok.token_first;
  assign out_if.token_last   = out_tok.token_last;

  // The front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && q_full))
    else $error("result pushed into full queue");

  // The back end only pops a queue that holds an entry
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");

  // End and error results are single-beat tokens without text
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.token_kind == stt_pkg::KIND_END ||
                      out_if.token_kind == stt_pkg::KIND_ERROR))
    |-> (out_if.token_first && out_if.token_last && !out_if.has_char))
    else $error("end or error result is not a single-beat token");

endmodule

// File: tb/sv/source_text_tokenizer_tb.sv
// Self-checking testbench of the source text tokenizer: byte stream in, token beats out.
module source_text_tokenizer_tb;

  // Run shape: random byte count, the output hold-off, the quiet-cycle watchdog and the drain.
  localparam int unsigned RANDOM_ITEMS   = 1600;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam logic [15:0] POS_MAX        = 16'hFFFF;

  typedef enum logic [5:0] {
    SCAN_IDLE     = 6'b000001,
    SCAN_WORD     = 6'b000010,
    SCAN_INT      = 6'b000100,
    SCAN_STR_OPEN = 6'b001000,
    SCAN_STR_BODY = 6'b010000,
    SCAN_HALT     = 6'b100000
  } scan_mode_t;

  // One row of the directed sequence: a source byte, and where the result is obvious,
  // the token beat it must produce.
  typedef struct packed {
    logic [7:0]    src;
    logic          typed;
    stt_pkg::tok_t want;
  } stim_row_t;

  localparam stt_pkg::tok_t NO_TOK  = '0;
  localparam stt_pkg::tok_t END_TOK = stt_pkg::tok_t'{stt_pkg::KIND_END, 1'b0,
                                                      stt_pkg::CH_NUL, 16'd0, 16'd0,
                                                      1'b1, 1'b1};
  localparam stt_pkg::tok_t FIRST_TOK = stt_pkg::tok_t'{stt_pkg::KIND_LPAREN, 1'b1,
                                                        stt_pkg::CH_LPAREN, 16'd1, 16'd1,
                                                        1'b1, 1'b1};

  // Punctuation, a word closed by punctuation, an int with letters closed by a tab,
  // an empty string, a string with a newline and a high byte, whitespace, end of text.
  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{stt_pkg::CH_LPAREN, 1'b1, FIRST_TOK},
    '{stt_pkg::CH_RPAREN, 1'b0, NO_TOK},
    '{stt_pkg::CH_LCURL,  1'b0, NO_TOK},
    '{stt_pkg::CH_RCURL,  1'b0, NO_TOK},
    '{stt_pkg::CH_SEMI,   1'b0, NO_TOK},
    '{stt_pkg::CH_COMMA,  1'b0, NO_TOK},
    '{stt_pkg::CH_UNDER,  1'b0, NO_TOK},
    '{"a",                1'b0, NO_TOK},
    '{"9",                1'b0, NO_TOK},
    '{"Z",                1'b0, NO_TOK},
    '{stt_pkg::CH_LPAREN, 1'b0, NO_TOK},
    '{"0",                1'b0, NO_TOK},
    '{"x",                1'b0, NO_TOK},
    '{"F",                1'b0, NO_TOK},
    '{stt_pkg::CH_TAB,    1'b0, NO_TOK},
    '{stt_pkg::CH_QUOTE,  1'b0, NO_TOK},
    '{stt_pkg::CH_QUOTE,  1'b0, NO_TOK},
    '{stt_pkg::CH_QUOTE,  1'b0, NO_TOK},
    '{stt_pkg::CH_NL,     1'b0, NO_TOK},
    '{8'hFF,              1'b0, NO_TOK},
    '{stt_pkg::CH_QUOTE,  1'b0, NO_TOK},
    '{stt_pkg::CH_VT,     1'b0, NO_TOK},
    '{stt_pkg::CH_SPACE,  1'b0, NO_TOK},
    '{stt_pkg::CH_NUL,    1'b1, END_TOK}
  };

  localparam logic [7:0] PUNCT_CHARS [6] = '{stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN,
                                             stt_pkg::CH_LCURL, stt_pkg::CH_RCURL,
                                             stt_pkg::CH_SEMI, stt_pkg::CH_COMMA};
  localparam logic [7:0] WHITE_CHARS [4] = '{stt_pkg::CH_TAB, stt_pkg::CH_VT,
                                             stt_pkg::CH_NL, stt_pkg::CH_SPACE};
  // Bytes the scanner does not know outside a string.
  localparam logic [7:0] STRAY_CHARS [8] = '{8'h0D, 8'h01, 8'h7F, 8'h80, 8'hFF,
                                             "#", "+", "@"};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  stt_in_if  src_ch ();
  stt_out_if tok_ch ();

  source_text_tokenizer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (src_ch),
    .out_if (tok_ch)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Scanner state of the predictor, starting from its reset values.
  scan_mode_t  scan_mode  = SCAN_IDLE;
  logic [15:0] line_count = 16'd1;
  logic [15:0] col_count  = 16'd0;
  logic [15:0] tok_line   = 16'd0;
  logic [15:0] tok_col    = 16'd0;

  stt_pkg::tok_t pending_tokens [$];
  bit            idle_on  = 1'b1;
  bit            hold_req = 1'b0;
  int unsigned   bytes_fed       = 0;
  int unsigned   results_checked = 0;
  int unsigned   mismatch_count  = 0;
  int unsigned   quiet_cycles    = 0;

  function automatic stt_pkg::tok_t emit(input logic [3:0] kind, input logic has,
                                         input logic [7:0] ch, input logic [15:0] ln, col,
                                         input logic first, last);
    return stt_pkg::tok_t'{kind, has, has ? ch : stt_pkg::CH_NUL, ln, col, first, last};
  endfunction

  // Advance the scanner by one source byte and collect the token beats it causes.
  function automatic void scan_byte(input logic [7:0] b, ref stt_pkg::tok_t found [$]);
    logic       letter, digit, alnum, opening;
    logic [3:0] kind;
    found.delete();
    if (scan_mode == SCAN_HALT) return;
    // Location of this byte: column first, a newline restarts at column 1.
    if (col_count != POS_MAX) col_count++;
    if (b == stt_pkg::CH_NL) begin
      if (line_count != POS_MAX) line_count++;
      col_count = 16'd1;
    end
    letter = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    digit  = b >= "0" && b <= "9";
    alnum  = letter || digit;
    case (scan_mode)
      SCAN_WORD, SCAN_INT: begin
        kind = (scan_mode == SCAN_WORD) ? stt_pkg::KIND_WORD : stt_pkg::KIND_INT;
        if (alnum || (scan_mode == SCAN_WORD && b == stt_pkg::CH_UNDER)) begin
          found.push_back(emit(kind, 1'b1, b, tok_line, tok_col, 1'b0, 1'b0));
          return;
        end
        // Close the token, then treat the byte as a fresh one.
        found.push_back(emit(kind, 1'b0, b, tok_line, tok_col, 1'b0, 1'b1));
        scan_mode = SCAN_IDLE;
      end
      SCAN_STR_OPEN, SCAN_STR_BODY: begin
        opening = scan_mode == SCAN_STR_OPEN;
        if (b == stt_pkg::CH_NUL) begin
          found.push_back(emit(stt_pkg::KIND_ERROR, 1'b0, b, line_count, col_count,
                               1'b1, 1'b1));
          scan_mode = SCAN_HALT;
          return;
        end
        if (opening) begin
          tok_line = line_count;
          tok_col  = col_count;
        end
        if (b == stt_pkg::CH_QUOTE) begin
          found.push_back(emit(stt_pkg::KIND_STRING, 1'b0, b, tok_line, tok_col,
                               opening, 1'b1));
          scan_mode = SCAN_IDLE;
        end else begin
          found.push_back(emit(stt_pkg::KIND_STRING, 1'b1, b, tok_line, tok_col,
                               opening, 1'b0));
          scan_mode = SCAN_STR_BODY;
        end
        return;
      end
      default: ;
    endcase
    if (b == stt_pkg::CH_TAB || b == stt_pkg::CH_VT || b == stt_pkg::CH_NL ||
        b == stt_pkg::CH_SPACE) return;
    if (b == stt_pkg::CH_NUL) begin
      found.push_back(END_TOK);
      line_count = 16'd1;
      col_count  = 16'd0;
      return;
    end
    if (alnum || b == stt_pkg::CH_UNDER) begin
      tok_line  = line_count;
      tok_col   = col_count;
      scan_mode = digit ? SCAN_INT : SCAN_WORD;
      found.push_back(emit(digit ? stt_pkg::KIND_INT : stt_pkg::KIND_WORD, 1'b1, b,
                           tok_line, tok_col, 1'b1, 1'b0));
      return;
    end
    if (b == stt_pkg::CH_QUOTE) begin
      scan_mode = SCAN_STR_OPEN;
      return;
    end
    case (b)
      stt_pkg::CH_LPAREN: kind = stt_pkg::KIND_LPAREN;
      stt_pkg::CH_RPAREN: kind = stt_pkg::KIND_RPAREN;
      stt_pkg::CH_LCURL:  kind = stt_pkg::KIND_LCURL;
      stt_pkg::CH_RCURL:  kind = stt_pkg::KIND_RCURL;
      stt_pkg::CH_SEMI:   kind = stt_pkg::KIND_SEMI;
      stt_pkg::CH_COMMA:  kind = stt_pkg::KIND_COMMA;
      default:            kind = stt_pkg::KIND_ERROR;
    endcase
    found.push_back(emit(kind, kind != stt_pkg::KIND_ERROR, b, line_count, col_count,
                         1'b1, 1'b1));
    if (kind == stt_pkg::KIND_ERROR) scan_mode = SCAN_HALT;
  endfunction

  // Idle length: mostly none, often short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Identifier characters: 0..25 lower case, 26..51 upper case, 52..61 digit, 62 '_'.
  function automatic logic [7:0] ident_char(input int unsigned top);
    int unsigned r;
    r = $urandom_range(0, top);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    if (r < 62) return "0" + 8'(r - 52);
    return stt_pkg::CH_UNDER;
  endfunction

  // Token and string lengths: mostly short, a few long.
  function automatic int unsigned run_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %0d want %0d",
             results_checked, what, got, want);
  endtask

  // Offer one source byte, hold it until the beat is taken, then predict its tokens.
  // A typed row supplies its own result in place of the prediction.
  task automatic feed(input logic [7:0] b, input logic typed = 1'b0,
                      input stt_pkg::tok_t want = '0);
    stt_pkg::tok_t found [$];
    int unsigned   gap;
    gap = idle_on ? gap_len() : 0;
    if (gap != 0) begin
      src_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_ch.valid      <= 1'b1;
    src_ch.byte_value <= b;
    do @(posedge clk); while (!src_ch.ready);
    bytes_fed++;
    scan_byte(b, found);
    if (typed) begin
      pending_tokens.push_back(want);
    end else begin
      foreach (found[i]) pending_tokens.push_back(found[i]);
    end
  endtask

  // Receiver: ready in random runs and gaps; one long hold-off on request so the
  // result queue fills and the byte input stalls.
  initial begin : token_sink
    int unsigned stall;
    tok_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        tok_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      tok_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      stall = idle_on ? gap_len() : 0;
      if (stall != 0) begin
        tok_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare every token beat taken with the oldest prediction, field by field.
  always @(posedge clk) begin : token_check
    stt_pkg::tok_t got, want;
    if (rst_n && tok_ch.valid && tok_ch.ready) begin
      got = stt_pkg::tok_t'{tok_ch.token_kind, tok_ch.has_char, tok_ch.char_out,
                            tok_ch.start_line, tok_ch.start_column, tok_ch.token_first,
                            tok_ch.token_last};
      results_checked++;
      if (pending_tokens.size() == 0) begin
        report_mismatch("token with none pending, kind", got.token_kind, 0);
      end else begin
        want = pending_tokens.pop_front();
        if (got.token_kind != want.token_kind)
          report_mismatch("token_kind", got.token_kind, want.token_kind);
        if (got.has_char != want.has_char)
          report_mismatch("has_char", got.has_char, want.has_char);
        if (got.char_out != want.char_out)
          report_mismatch("char_out", got.char_out, want.char_out);
        if (got.start_line != want.start_line)
          report_mismatch("start_line", got.start_line, want.start_line);
        if (got.start_column != want.start_column)
          report_mismatch("start_column", got.start_column, want.start_column);
        if (got.token_first != want.token_first)
          report_mismatch("token_first", got.token_first, want.token_first);
        if (got.token_last != want.token_last)
          report_mismatch("token_last", got.token_last, want.token_last);
      end
    end
  end

  // Watchdog: end the run once no beat has moved on either side for too long.
  always @(posedge clk) begin : stall_watch
    if (!rst_n || (src_ch.valid && src_ch.ready) || (tok_ch.valid && tok_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d tokens still pending",
               WATCHDOG_LIMIT, pending_tokens.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick, random_start, hold_at;
    logic [7:0]  c;
    string       halt_reason;
    src_ch.valid      <= 1'b0;
    src_ch.byte_value <= stt_pkg::CH_NUL;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, walked in order.
    foreach (DIRECTED_ROWS[i])
      feed(DIRECTED_ROWS[i].src, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    // Random source text: mostly well-formed tokens with random content, some stray
    // quotes and raw bytes inside strings, an end of text now and then.
    random_start = bytes_fed;
    hold_at      = random_start + $urandom_range(300, 700);
    while (bytes_fed < random_start + RANDOM_ITEMS) begin
      if (hold_at != 0 && bytes_fed >= hold_at) begin
        hold_req = 1'b1;
        hold_at  = 0;
      end
      // Toggle stretches with no idling on either side.
      if ($urandom_range(0, 59) == 0) idle_on = !idle_on;
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        feed(($urandom_range(0, 9) == 0) ? stt_pkg::CH_UNDER : ident_char(51));
        repeat (run_len()) feed(ident_char(62));
      end else if (pick < 42) begin
        feed(ident_char(9) - "a" + "0");
        repeat (run_len()) feed(ident_char(61));
      end else if (pick < 57) begin
        // Close a string left open by a stray quote, so the raw text lands inside one.
        if (scan_mode == SCAN_STR_OPEN || scan_mode == SCAN_STR_BODY)
          feed(stt_pkg::CH_QUOTE);
        feed(stt_pkg::CH_QUOTE);
        repeat (run_len()) begin
          do begin
            c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(32, 126))
                                             : 8'($urandom_range(1, 255));
          end while (c == stt_pkg::CH_QUOTE);
          feed(c);
        end
        feed(stt_pkg::CH_QUOTE);
      end else if (pick < 77) begin
        feed(PUNCT_CHARS[$urandom_range(0, 5)]);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 3)) feed(WHITE_CHARS[$urandom_range(0, 3)]);
      end else if (pick < 96) begin
        // Close an open string first: byte 0 inside one would halt the scanner.
        if (scan_mode == SCAN_STR_OPEN || scan_mode == SCAN_STR_BODY)
          feed(stt_pkg::CH_QUOTE);
        feed(stt_pkg::CH_NUL);
      end else if (scan_mode == SCAN_STR_OPEN || scan_mode == SCAN_STR_BODY) begin
        feed(($urandom_range(0, 1) != 0) ? stt_pkg::CH_QUOTE : 8'($urandom_range(1, 255)));
      end else begin
        feed(stt_pkg::CH_QUOTE);
      end
    end
    idle_on = 1'b1;
    // Leave the scanner idle so the end of text gives its single result.
    if (scan_mode == SCAN_STR_OPEN || scan_mode == SCAN_STR_BODY)
      feed(stt_pkg::CH_QUOTE);
    else if (scan_mode == SCAN_WORD || scan_mode == SCAN_INT)
      feed(stt_pkg::CH_SPACE);
    feed(stt_pkg::CH_NUL, 1'b1, END_TOK);

    // Halt the scanner once, right at the start of a fresh text, then keep feeding
    // bytes that must be taken and dropped.
    if ($urandom_range(0, 2) != 0) begin
      c = ($urandom_range(0, 2) != 0) ? STRAY_CHARS[$urandom_range(0, 7)]
                                      : 8'($urandom_range(128, 255));
      halt_reason = $sformatf("unknown byte 0x%02h", c);
      feed(c, 1'b1, stt_pkg::tok_t'{stt_pkg::KIND_ERROR, 1'b0, stt_pkg::CH_NUL,
                                    16'd1, 16'd1, 1'b1, 1'b1});
    end else begin
      halt_reason = "unterminated string";
      feed(stt_pkg::CH_QUOTE);
      feed(stt_pkg::CH_NUL, 1'b1, stt_pkg::tok_t'{stt_pkg::KIND_ERROR, 1'b0,
                                                  stt_pkg::CH_NUL, 16'd1, 16'd2,
                                                  1'b1, 1'b1});
    end
    repeat (6) feed(8'($urandom_range(0, 255)));
    src_ch.valid <= 1'b0;

    // Drain: wait for every predicted token, then watch a little longer for extras.
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d source bytes of directed and random text", bytes_fed);
    $display("and %0d token beats under %0d-cycle hold-off; halted on %s.",
             results_checked, HOLD_CYCLES, halt_reason);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/stt_pkg.sv
hw/rtl/stt_in_if.sv
hw/rtl/stt_out_if.sv
hw/rtl/stt_front.sv
hw/rtl/stt_queue.sv
hw/rtl/stt_back.sv
hw/rtl/source_text_tokenizer.sv
tb/sv/source_text_tokenizer_tb.sv
